[sv/pidsc_pkg.sv]
// pidsc_pkg: shared widths, register indexes, control word types and the
// microcode ROM of the PID speed controller.
// No dependencies; used by pidsc_if.sv, pidsc_sequencer.sv and the top level.
package pidsc_pkg;

   localparam int GAIN_WIDTH     = 16;
   localparam int SETPOINT_WIDTH = 16;
   localparam int START_WIDTH    = 32;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int ACC_WIDTH      = 64;   // clamped PID sum, +-2^61
   localparam int WIDE_WIDTH     = 66;   // product or sum before clamping
   localparam int TERM_MSB       = 61;
   localparam int SCALE_SPLIT    = 16;   // overall gain applied to the sum in two halves, split at bit 16
   localparam int SCALE_OP_WIDTH = 47;   // upper half of the sum as a signed operand
   localparam int FULL_WIDTH     = 78;   // sum times overall gain
   localparam int STEP_WIDTH     = 3;

   localparam logic [GAIN_WIDTH-1:0]         OVERALL_GAIN_RESET   = 16'd256;
   localparam logic signed [START_WIDTH-1:0] INTEGRAL_START_RESET = 32'sd150;

   localparam logic signed [WIDE_WIDTH-1:0] TERM_LIMIT =
      WIDE_WIDTH'(64'h2000_0000_0000_0000);

   // register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SETPOINT       = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_GAIN_PROP      = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_GAIN_INTEG     = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_GAIN_DERIV     = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_OVERALL_GAIN   = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_INTEGRAL_START = 3'd5;

   typedef logic [STEP_WIDTH-1:0] step_type;

   localparam step_type STEP_PROP     = 3'd0;
   localparam step_type STEP_INTEG    = 3'd1;
   localparam step_type STEP_DERIV    = 3'd2;
   localparam step_type STEP_SUM      = 3'd3;
   localparam step_type STEP_SCALE_HI = 3'd4;
   localparam step_type STEP_SCALE_LO = 3'd5;
   localparam step_type STEP_FULL     = 3'd6;
   localparam step_type STEP_EMIT     = 3'd7;

   typedef enum logic [1:0] {
      GAIN_KP,
      GAIN_KI,
      GAIN_KD,
      GAIN_OVERALL
   } gain_sel_type;

   typedef enum logic [2:0] {
      OP_ERR,
      OP_INTEG,
      OP_DSPD,
      OP_ACC_HI,
      OP_ACC_LO
   } op_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD,
      ACC_FULL_HI,
      ACC_FULL_ADD
   } acc_op_type;

   typedef enum logic {
      JMP_NONE,
      JMP_NOT_POS
   } jump_type;

   typedef struct packed {
      logic         upd_int;
      logic         mul_en;
      gain_sel_type gain_sel;
      op_sel_type   op_sel;
      acc_op_type   acc_op;
      jump_type     jump;
      step_type     target;
      logic         emit;
   } ctrl_word_type;

   typedef struct packed {
      logic start;
      logic not_pos;
      logic out_stall;
   } seq_status_type;

   typedef struct packed {
      logic          idle;
      ctrl_word_type cw;
   } seq_ctrl_type;

   localparam ctrl_word_type CW_NOP = '{
      upd_int:  1'b0,
      mul_en:   1'b0,
      gain_sel: GAIN_KP,
      op_sel:   OP_ERR,
      acc_op:   ACC_NONE,
      jump:     JMP_NONE,
      target:   STEP_PROP,
      emit:     1'b0
   };

   // microcode: multiply issued in one step, product consumed in the next
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type cw;
      cw = CW_NOP;
      unique case (step)
         STEP_PROP: begin
            cw.upd_int  = 1'b1;
            cw.mul_en   = 1'b1;
            cw.gain_sel = GAIN_KP;
            cw.op_sel   = OP_ERR;
         end
         STEP_INTEG: begin
            cw.mul_en   = 1'b1;
            cw.gain_sel = GAIN_KI;
            cw.op_sel   = OP_INTEG;
            cw.acc_op   = ACC_LOAD;
         end
         STEP_DERIV: begin
            cw.mul_en   = 1'b1;
            cw.gain_sel = GAIN_KD;
            cw.op_sel   = OP_DSPD;
            cw.acc_op   = ACC_ADD;
         end
         STEP_SUM: begin
            cw.acc_op   = ACC_ADD;
         end
         STEP_SCALE_HI: begin
            cw.mul_en   = 1'b1;
            cw.gain_sel = GAIN_OVERALL;
            cw.op_sel   = OP_ACC_HI;
            cw.jump     = JMP_NOT_POS;
            cw.target   = STEP_EMIT;
         end
         STEP_SCALE_LO: begin
            cw.mul_en   = 1'b1;
            cw.gain_sel = GAIN_OVERALL;
            cw.op_sel   = OP_ACC_LO;
            cw.acc_op   = ACC_FULL_HI;
         end
         STEP_FULL: begin
            cw.acc_op   = ACC_FULL_ADD;
         end
         STEP_EMIT: begin
            cw.emit     = 1'b1;
         end
      endcase
      return cw;
   endfunction

   function automatic logic signed [ACC_WIDTH-1:0] clamp_term(
      input logic signed [WIDE_WIDTH-1:0] v
   );
      logic signed [WIDE_WIDTH-1:0] r;
      if (v > TERM_LIMIT) begin
         r = TERM_LIMIT;
      end else if (v < -TERM_LIMIT) begin
         r = -TERM_LIMIT;
      end else begin
         r = v;
      end
      return r[ACC_WIDTH-1:0];
   endfunction

endpackage

[sv/pidsc_if.sv]
// pidsc_if: valid/ready channel interfaces of the PID speed controller
// (tick requests, drive results, register writes). Depends on pidsc_pkg.
interface pidsc_req_if #(parameter int SPEED_WIDTH = 16) ();
   logic                   valid;
   logic                   ready;
   logic [SPEED_WIDTH-1:0] measured_speed;
   logic                   motor_running;
   logic                   clear_integral;

   modport source (output valid, measured_speed, motor_running, clear_integral,
                   input ready);
   modport sink   (input valid, measured_speed, motor_running, clear_integral,
                   output ready);
endinterface

interface pidsc_rsp_if #(parameter int DRIVE_WIDTH = 13) ();
   logic                   valid;
   logic                   ready;
   logic [DRIVE_WIDTH-1:0] drive_level;
   logic                   clamped_high;
   logic                   clamped_low;

   modport source (output valid, drive_level, clamped_high, clamped_low,
                   input ready);
   modport sink   (input valid, drive_level, clamped_high, clamped_low,
                   output ready);
endinterface

interface pidsc_csr_if ();
   logic                                valid;
   logic                                ready;
   logic [pidsc_pkg::CSR_ADDR_WIDTH-1:0] addr;
   logic [pidsc_pkg::CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

[sv/pidsc_sequencer.sv]
// pidsc_sequencer: step counter and microcode ROM fetch with conditional jump.
// Depends on pidsc_pkg (control word types, ucode_rom).
module pidsc_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  pidsc_pkg::seq_status_type status,
   output pidsc_pkg::seq_ctrl_type   ctrl
);

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   seq_state_type             state_ff, state_in;
   pidsc_pkg::step_type       step_ff, step_in;
   pidsc_pkg::ctrl_word_type  cw;

   assign cw = (state_ff == SEQ_RUN) ? pidsc_pkg::ucode_rom(step_ff) : pidsc_pkg::CW_NOP;
   assign ctrl.idle = (state_ff == SEQ_IDLE);
   assign ctrl.cw   = cw;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (status.start) begin
               state_in = SEQ_RUN;
               step_in  = pidsc_pkg::STEP_PROP;
            end
         end
         SEQ_RUN: begin
            priority if (cw.emit && status.out_stall) begin
               step_in = step_ff;                 // hold until output frees
            end else if (cw.emit) begin
               state_in = SEQ_IDLE;
            end else if (cw.jump == pidsc_pkg::JMP_NOT_POS && status.not_pos) begin
               step_in = cw.target;
            end else begin
               step_in = step_ff + pidsc_pkg::STEP_WIDTH'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= pidsc_pkg::STEP_PROP;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[sv/pid_speed_controller_unit.sv]
// pid_speed_controller_unit: top level of the PID speed controller, register
// file, datapath and output register. Depends on pidsc_pkg, pidsc_if.sv and
// pidsc_sequencer.
//
// One request transaction per control tick. A tick with clear_integral set
// reloads the integral from integral_start and gives no response; a tick
// with neither flag does nothing; both leave the sequencer idle. A running
// tick latches error and speed delta in the accept cycle, then a microcoded
// sequencer drives one shared 16-bit-gain multiplier through up to eight
// steps: integral update and kp*error, ki*integral, kd*dspeed, the saturating
// sum, then overall gain on the two halves of the sum, split at bit 16, and
// the clamp. The scaling steps are skipped when the sum is not positive or
// overall gain is zero; req_ready is low while the sequencer runs. A finished
// response sits in an output register, so a new request is taken while it
// waits; the sequencer only stalls at its emit step if the previous response
// is still unread. Registers are written through the csr channel (always
// ready); the user must write them only while the block is idle, which the
// block itself does not enforce; indexes 6 and 7 are ignored.
module pid_speed_controller_unit #(
   parameter int SPEED_WIDTH    = 16,
   parameter int INTEGRAL_WIDTH = 32,
   parameter int GAIN_FRAC_BITS = 8,
   parameter int DRIVE_MAX      = 6553
) (
   input  logic        clock,
   input  logic        reset,
   pidsc_req_if.sink   req_ch,
   pidsc_rsp_if.source rsp_ch,
   pidsc_csr_if.sink   csr_ch
);

   localparam int DRIVE_WIDTH = $clog2(DRIVE_MAX + 1);
   localparam int ERR_WIDTH   =
      ((SPEED_WIDTH > pidsc_pkg::SETPOINT_WIDTH) ? SPEED_WIDTH : pidsc_pkg::SETPOINT_WIDTH) + 1;
   localparam int DSPD_WIDTH  = SPEED_WIDTH + 1;
   localparam int OP_BASE     = (INTEGRAL_WIDTH > ERR_WIDTH) ? INTEGRAL_WIDTH : ERR_WIDTH;
   localparam int OP_WIDTH    =
      (OP_BASE > pidsc_pkg::SCALE_OP_WIDTH) ? OP_BASE : pidsc_pkg::SCALE_OP_WIDTH;
   localparam int PROD_WIDTH  = OP_WIDTH + pidsc_pkg::GAIN_WIDTH + 1;
   localparam int SUM_WIDTH   = OP_WIDTH + 1;
   localparam int GW          = pidsc_pkg::GAIN_WIDTH;
   localparam int AW          = pidsc_pkg::ACC_WIDTH;
   localparam int WW          = pidsc_pkg::WIDE_WIDTH;
   localparam int FW          = pidsc_pkg::FULL_WIDTH;
   localparam int SPLIT       = pidsc_pkg::SCALE_SPLIT;

   // saturate a wide signed value into the integral's width
   function automatic logic signed [INTEGRAL_WIDTH-1:0] clamp_int(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic [SUM_WIDTH-INTEGRAL_WIDTH:0] top;
      logic                              fits;
      top  = v[SUM_WIDTH-1:INTEGRAL_WIDTH-1];
      fits = (&top) || !(|top);
      return fits ? v[INTEGRAL_WIDTH-1:0]
                  : {v[SUM_WIDTH-1], {(INTEGRAL_WIDTH-1){~v[SUM_WIDTH-1]}}};
   endfunction

   // configuration registers
   logic [pidsc_pkg::SETPOINT_WIDTH-1:0]     setpoint_ff, setpoint_in;
   logic [GW-1:0]                            kp_ff, kp_in;
   logic [GW-1:0]                            ki_ff, ki_in;
   logic [GW-1:0]                            kd_ff, kd_in;
   logic [GW-1:0]                            og_ff, og_in;
   logic signed [pidsc_pkg::START_WIDTH-1:0] start_ff, start_in;

   // controller state and datapath
   logic signed [INTEGRAL_WIDTH-1:0] integral_ff, integral_in;
   logic [SPEED_WIDTH-1:0]           prev_ff, prev_in;
   logic signed [ERR_WIDTH-1:0]      err_ff, err_in;
   logic signed [DSPD_WIDTH-1:0]     dspd_ff, dspd_in;
   logic signed [PROD_WIDTH-1:0]     prod_ff, prod_in;
   logic signed [AW-1:0]             acc_ff, acc_in;
   logic [FW-1:0]                    full_ff, full_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_WIDTH-1:0] drive_ff, drive_in;
   logic                   hi_ff, hi_in;
   logic                   lo_ff, lo_in;

   logic                      req_accept;
   logic                      csr_write;
   logic                      out_stall;
   logic                      not_pos;
   logic [GW-1:0]             gain_mux;
   logic signed [OP_WIDTH-1:0] op_mux;
   logic signed [WW-1:0]      prod_wide;
   logic signed [SUM_WIDTH-1:0] int_sum;
   logic [FW-1:0]             raw;
   logic                      raw_hi;

   pidsc_pkg::seq_status_type seq_status;
   pidsc_pkg::seq_ctrl_type   seq_ctrl;

   assign req_ch.ready = seq_ctrl.idle;
   assign csr_ch.ready = 1'b1;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_write    = csr_ch.valid && csr_ch.ready;
   assign out_stall    = rsp_valid_ff && !rsp_ch.ready;

   // sum not positive or no gain: the scaling steps are skipped, drive is 0
   assign not_pos = acc_ff[AW-1] || (acc_ff == '0) || (og_ff == '0);

   assign seq_status.start     = req_accept && req_ch.motor_running && !req_ch.clear_integral;
   assign seq_status.not_pos   = not_pos;
   assign seq_status.out_stall = out_stall;

   pidsc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (seq_status),
      .ctrl   (seq_ctrl)
   );

   // shared multiplier operand selection
   always_comb begin
      unique case (seq_ctrl.cw.gain_sel)
         pidsc_pkg::GAIN_KP:      gain_mux = kp_ff;
         pidsc_pkg::GAIN_KI:      gain_mux = ki_ff;
         pidsc_pkg::GAIN_KD:      gain_mux = kd_ff;
         pidsc_pkg::GAIN_OVERALL: gain_mux = og_ff;
      endcase
      unique case (seq_ctrl.cw.op_sel)
         pidsc_pkg::OP_ERR:    op_mux = OP_WIDTH'(err_ff);
         pidsc_pkg::OP_INTEG:  op_mux = OP_WIDTH'(integral_ff);
         pidsc_pkg::OP_DSPD:   op_mux = OP_WIDTH'(dspd_ff);
         pidsc_pkg::OP_ACC_HI: op_mux = OP_WIDTH'({1'b0, acc_ff[pidsc_pkg::TERM_MSB:SPLIT]});
         pidsc_pkg::OP_ACC_LO: op_mux = OP_WIDTH'({1'b0, acc_ff[SPLIT-1:0]});
         default:              op_mux = '0;
      endcase
   end

   assign prod_in   = $signed({1'b0, gain_mux}) * op_mux;
   assign prod_wide = WW'(prod_ff);
   assign int_sum   = SUM_WIDTH'(integral_ff) + SUM_WIDTH'(err_ff);

   // drop the 2*GAIN_FRAC_BITS fraction bits, floor
   assign raw    = full_ff >> (2 * GAIN_FRAC_BITS);
   assign raw_hi = raw > FW'(DRIVE_MAX);

   always_comb begin
      setpoint_in  = setpoint_ff;
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      kd_in        = kd_ff;
      og_in        = og_ff;
      start_in     = start_ff;
      integral_in  = integral_ff;
      prev_in      = prev_ff;
      err_in       = err_ff;
      dspd_in      = dspd_ff;
      acc_in       = acc_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff;
      drive_in     = drive_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;

      if (csr_write) begin
         unique case (csr_ch.addr)
            pidsc_pkg::CSR_SETPOINT:       setpoint_in = csr_ch.data[pidsc_pkg::SETPOINT_WIDTH-1:0];
            pidsc_pkg::CSR_GAIN_PROP:      kp_in       = csr_ch.data[GW-1:0];
            pidsc_pkg::CSR_GAIN_INTEG:     ki_in       = csr_ch.data[GW-1:0];
            pidsc_pkg::CSR_GAIN_DERIV:     kd_in       = csr_ch.data[GW-1:0];
            pidsc_pkg::CSR_OVERALL_GAIN:   og_in       = csr_ch.data[GW-1:0];
            pidsc_pkg::CSR_INTEGRAL_START: start_in    = csr_ch.data[pidsc_pkg::START_WIDTH-1:0];
            default: ;
         endcase
      end

      // tick transaction: clear wins over running
      if (req_accept) begin
         if (req_ch.clear_integral) begin
            integral_in = clamp_int(SUM_WIDTH'(start_ff));
         end else if (req_ch.motor_running) begin
            err_in  = ERR_WIDTH'(setpoint_ff) - ERR_WIDTH'(req_ch.measured_speed);
            dspd_in = DSPD_WIDTH'(prev_ff) - DSPD_WIDTH'(req_ch.measured_speed);
            prev_in = req_ch.measured_speed;
         end
      end

      if (seq_ctrl.cw.upd_int) begin
         integral_in = clamp_int(int_sum);
      end

      unique case (seq_ctrl.cw.acc_op)
         pidsc_pkg::ACC_NONE:     ;
         pidsc_pkg::ACC_LOAD:     acc_in = pidsc_pkg::clamp_term(prod_wide);
         pidsc_pkg::ACC_ADD:      acc_in = pidsc_pkg::clamp_term(
                                     WW'(acc_ff) + WW'(pidsc_pkg::clamp_term(prod_wide)));
         pidsc_pkg::ACC_FULL_HI:  full_in = {prod_ff[FW-SPLIT-1:0], {SPLIT{1'b0}}};
         pidsc_pkg::ACC_FULL_ADD: full_in = full_ff + FW'(prod_ff[2*SPLIT-1:0]);
         default: ;
      endcase

      // output register: load at emit, else drain on ready
      if (seq_ctrl.cw.emit && !out_stall) begin
         rsp_valid_in = 1'b1;
         if (not_pos) begin
            drive_in = '0;
            hi_in    = 1'b0;
            lo_in    = acc_ff[AW-1] && (og_ff != '0);
         end else begin
            drive_in = raw_hi ? DRIVE_WIDTH'(DRIVE_MAX) : raw[DRIVE_WIDTH-1:0];
            hi_in    = raw_hi;
            lo_in    = 1'b0;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= '0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         og_ff        <= pidsc_pkg::OVERALL_GAIN_RESET;
         start_ff     <= pidsc_pkg::INTEGRAL_START_RESET;
         integral_ff  <= INTEGRAL_WIDTH'(pidsc_pkg::INTEGRAL_START_RESET);
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         setpoint_ff  <= setpoint_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         og_ff        <= og_in;
         start_ff     <= start_in;
         integral_ff  <= integral_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      dspd_ff  <= dspd_in;
      acc_ff   <= acc_in;
      full_ff  <= full_in;
      drive_ff <= drive_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      if (seq_ctrl.cw.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.drive_level  = drive_ff;
   assign rsp_ch.clamped_high = hi_ff;
   assign rsp_ch.clamped_low  = lo_ff;

`ifndef SYNTHESIS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      seq_status.start |=> !seq_ctrl.idle)
      else $error("running tick did not start the sequencer");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (seq_ctrl.cw.emit && out_stall) |=> !seq_ctrl.idle)
      else $error("sequencer left emit step while output was held");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (drive_ff <= DRIVE_WIDTH'(DRIVE_MAX)))
      else $error("drive level above maximum");

   a_flag_hi: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && hi_ff) |-> (drive_ff == DRIVE_WIDTH'(DRIVE_MAX) && !lo_ff))
      else $error("clamped_high without drive at maximum");

   a_flag_lo: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && lo_ff) |-> (drive_ff == '0))
      else $error("clamped_low with nonzero drive");
`endif

endmodule

[sim/tb.sv]
// tb.sv: self-checking testbench of pid_speed_controller_unit. A drive scoreboard
// predicts each drive result and checks the block's results in order.
// Depends on pidsc_pkg, the channel interfaces in pidsc_if.sv and the controller RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     SPEED_W       = 16;
   localparam int     DRIVE_W       = 13;
   localparam int     DRIVE_CEIL    = 6553;
   localparam int     PRODUCT_SHIFT = 16;      // two Q8.8 scalings
   localparam longint SUM_CAP       = 64'sh2000_0000_0000_0000;
   localparam longint INTEG_HI      = 64'sd2147483647;
   localparam longint INTEG_LO      = -64'sd2147483648;
   localparam logic [pidsc_pkg::CSR_ADDR_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [pidsc_pkg::CSR_ADDR_WIDTH-1:0] CSR_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 16;          // covers the busy window of a running tick
   localparam int DRAIN_LIMIT   = 5000;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int HOLD_AFTER    = 300;         // results seen before the long hold-off
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_PHASES = 8;
   localparam int RUNS_PER_PHASE = 120;

   typedef struct packed {
      logic [DRIVE_W-1:0] level;
      logic               high;
      logic               low;
   } drive_type;

   // Predicts the drive result of every running tick and checks results in order.
   class drive_scoreboard;
      logic [pidsc_pkg::GAIN_WIDTH-1:0]         setpoint, kp, ki, kd, overall;
      logic signed [pidsc_pkg::START_WIDTH-1:0] start_val, integ;
      logic [SPEED_W-1:0]                       prev_speed;
      drive_type                                expected_q[$];
      int errors, checked, ticks, writes, n_high, n_low;

      function new();
         setpoint   = '0;
         kp         = '0;
         ki         = '0;
         kd         = '0;
         overall    = pidsc_pkg::OVERALL_GAIN_RESET;
         start_val  = pidsc_pkg::INTEGRAL_START_RESET;
         integ      = pidsc_pkg::INTEGRAL_START_RESET;
         prev_speed = '0;
         errors = 0; checked = 0; ticks = 0; writes = 0; n_high = 0; n_low = 0;
      endfunction

      function longint saturate(longint v, longint hi, longint lo);
         return (v > hi) ? hi : ((v < lo) ? lo : v);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(logic [pidsc_pkg::CSR_ADDR_WIDTH-1:0] idx,
                              logic [pidsc_pkg::CSR_DATA_WIDTH-1:0] data);
         writes++;
         unique case (idx)
            pidsc_pkg::CSR_SETPOINT:       setpoint  = data[pidsc_pkg::GAIN_WIDTH-1:0];
            pidsc_pkg::CSR_GAIN_PROP:      kp        = data[pidsc_pkg::GAIN_WIDTH-1:0];
            pidsc_pkg::CSR_GAIN_INTEG:     ki        = data[pidsc_pkg::GAIN_WIDTH-1:0];
            pidsc_pkg::CSR_GAIN_DERIV:     kd        = data[pidsc_pkg::GAIN_WIDTH-1:0];
            pidsc_pkg::CSR_OVERALL_GAIN:   overall   = data[pidsc_pkg::GAIN_WIDTH-1:0];
            pidsc_pkg::CSR_INTEGRAL_START: start_val = data;
            default: ;
         endcase
      endfunction

      function void note_tick(logic [SPEED_W-1:0] speed, logic running, logic clear);
         longint      err, dspd, sum;
         logic [79:0] scaled;
         drive_type   d;
         ticks++;
         if (clear) begin
            integ = start_val;
            return;
         end
         if (!running) return;
         err   = longint'(setpoint) - longint'(speed);
         integ = pidsc_pkg::START_WIDTH'(saturate(longint'(integ) + err, INTEG_HI, INTEG_LO));
         dspd  = longint'(prev_speed) - longint'(speed);
         prev_speed = speed;
         sum = saturate(longint'(kp) * err, SUM_CAP, -SUM_CAP);
         sum = saturate(sum + saturate(longint'(ki) * longint'(integ), SUM_CAP, -SUM_CAP),
                        SUM_CAP, -SUM_CAP);
         sum = saturate(sum + saturate(longint'(kd) * dspd, SUM_CAP, -SUM_CAP),
                        SUM_CAP, -SUM_CAP);
         d = '0;
         if (overall == 0 || sum == 0) begin
            d.level = '0;
         end else if (sum < 0) begin
            d.low = 1'b1;
         end else begin
            scaled = (80'(sum) * 80'(overall)) >> PRODUCT_SHIFT;
            if (scaled > DRIVE_CEIL) begin
               d.high  = 1'b1;
               d.level = DRIVE_W'(DRIVE_CEIL);
            end else begin
               d.level = scaled[DRIVE_W-1:0];
            end
         end
         expected_q.push_back(d);
      endfunction

      function void check_drive(drive_type got);
         drive_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected drive result level %0d high %0b low %0b",
                     $time, got.level, got.high, got.low);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         n_high += int'(want.high);
         n_low  += int'(want.low);
         if (got.level !== want.level) begin
            errors++;
            $display("%0t: drive_level expected %0d actual %0d", $time, want.level, got.level);
         end
         if (got.high !== want.high) begin
            errors++;
            $display("%0t: clamped_high expected %0b actual %0b", $time, want.high, got.high);
         end
         if (got.low !== want.low) begin
            errors++;
            $display("%0t: clamped_low expected %0b actual %0b", $time, want.low, got.low);
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   bit   no_idle = 1'b0;     // both sides run back to back while set

   drive_scoreboard sb = new();

   pidsc_req_if #(.SPEED_WIDTH(SPEED_W)) req_bus ();
   pidsc_rsp_if #(.DRIVE_WIDTH(DRIVE_W)) rsp_bus ();
   pidsc_csr_if                          csr_bus ();

   pid_speed_controller_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one tick transaction; valid stays high into the next call when no gap is drawn
   task automatic send_tick(input logic [SPEED_W-1:0] speed, input logic running,
                            input logic clear);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.measured_speed <= speed;
      req_bus.motor_running  <= running;
      req_bus.clear_integral <= clear;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_tick(speed, running, clear);
   endtask

   // stop offering ticks, wait out every pending result and the busy window
   task automatic drain_and_settle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [pidsc_pkg::CSR_ADDR_WIDTH-1:0] idx,
                            input logic [pidsc_pkg::CSR_DATA_WIDTH-1:0] data,
                            input bit last);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.write_reg(idx, data);
      if (last) csr_bus.valid <= 1'b0;
   endtask

   // full register set; junk in the unused upper bits of the 16-bit registers
   task automatic program_regs(input logic [15:0] sp, input logic [15:0] p_gain,
                               input logic [15:0] i_gain, input logic [15:0] d_gain,
                               input logic [15:0] o_gain, input logic [31:0] start);
      drain_and_settle();
      csr_write(pidsc_pkg::CSR_SETPOINT,       {16'($urandom), sp},     1'b0);
      csr_write(pidsc_pkg::CSR_GAIN_PROP,      {16'($urandom), p_gain}, 1'b0);
      csr_write(pidsc_pkg::CSR_GAIN_INTEG,     {16'($urandom), i_gain}, 1'b0);
      csr_write(pidsc_pkg::CSR_GAIN_DERIV,     {16'($urandom), d_gain}, 1'b0);
      csr_write(pidsc_pkg::CSR_OVERALL_GAIN,   {16'($urandom), o_gain}, 1'b0);
      csr_write(pidsc_pkg::CSR_INTEGRAL_START, start,                   1'b1);
   endtask

   function automatic logic [15:0] pick_gain(input bit wild);
      int r;
      if (!wild) return 16'($urandom_range(0, 512));
      r = $urandom_range(0, 2);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // random phase: mostly running ticks near the setpoint so the loop settles
   // into the unclamped range, plus full-range speeds, clears and idle ticks
   task automatic random_phase(input int runs, input bit wild);
      logic [15:0] sp, og;
      logic [31:0] start;
      logic [15:0] speed;
      int          done, r;
      sp = 16'($urandom);
      og = wild ? pick_gain(1'b1) : (($urandom_range(0, 3) == 0) ? 16'd256 : pick_gain(1'b0));
      r  = $urandom_range(0, 2);
      if (!wild)       start = 32'($urandom_range(0, 20000)) - 32'd10000;
      else if (r == 0) start = 32'h7FFF_FFFF;
      else if (r == 1) start = 32'h8000_0000;
      else             start = $urandom;
      program_regs(sp, pick_gain(wild), wild ? pick_gain(1'b1) : 16'($urandom_range(0, 16)),
                   pick_gain(wild), og, start);
      done = 0;
      while (done < runs) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 9) < 7) speed = 16'(sp + $urandom_range(0, 600) - 300);
         else                          speed = 16'($urandom);
         if (r < 6) begin
            send_tick(speed, 1'($urandom), 1'b1);
         end else if (r < 12) begin
            send_tick(speed, 1'b0, 1'b0);
         end else begin
            send_tick(speed, 1'b1, 1'b0);
            done++;
         end
      end
   endtask

   // main stimulus: directed corners, then random phases under several settings
   initial begin : stimulus
      int waited;
      req_bus.valid          <= 1'b0;
      req_bus.measured_speed <= '0;
      req_bus.motor_running  <= 1'b0;
      req_bus.clear_integral <= 1'b0;
      csr_bus.valid          <= 1'b0;
      csr_bus.addr           <= '0;
      csr_bus.data           <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset values: only ki is set, so the drive shows the reset start value
      // and the reset overall gain; unused indexes must be ignored
      csr_write(CSR_SPARE_LO,              32'hFFFF_FFFF, 1'b0);
      csr_write(CSR_SPARE_HI,              32'h0000_0000, 1'b0);
      csr_write(pidsc_pkg::CSR_GAIN_INTEG, 32'd256,       1'b1);
      send_tick(16'h0000, 1'b1, 1'b0);
      send_tick(16'hFFFF, 1'b1, 1'b0);          // large negative error
      send_tick(16'h0000, 1'b0, 1'b1);          // clear only
      send_tick(16'h0000, 1'b1, 1'b1);          // clear wins over running
      send_tick(16'h1234, 1'b0, 1'b0);          // idle tick

      // mid-range P and D, previous speed still from before the clear
      program_regs(16'd1000, 16'd256, 16'd0, 16'd256, 16'd256, 32'd150);
      send_tick(16'd1000, 1'b1, 1'b0);
      send_tick(16'd0,    1'b1, 1'b0);
      send_tick(16'd1000, 1'b1, 1'b0);
      send_tick(16'd1000, 1'b1, 1'b0);

      // every field at its top, integral pinned at its upper limit
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
      send_tick(16'h0000, 1'b0, 1'b1);
      send_tick(16'h0000, 1'b1, 1'b0);
      send_tick(16'hFFFF, 1'b1, 1'b0);

      // integral pinned at its lower limit
      program_regs(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'd256, 32'h8000_0000);
      send_tick(16'h0000, 1'b0, 1'b1);
      send_tick(16'hFFFF, 1'b1, 1'b0);
      send_tick(16'h0000, 1'b1, 1'b0);

      // raw lands just below DRIVE_CEIL+1: floored to the ceiling, no high flag
      program_regs(16'd6553, 16'd256, 16'd1, 16'd0, 16'd256, -32'sd6298);
      send_tick(16'h0000, 1'b0, 1'b1);
      send_tick(16'h0000, 1'b1, 1'b0);
      send_tick(16'h0000, 1'b1, 1'b0);

      // zero overall gain: no drive and no flag either way
      program_regs(16'd6553, 16'd256, 16'd1, 16'd0, 16'd0, 32'd150);
      send_tick(16'h0000, 1'b1, 1'b0);
      send_tick(16'hFFFF, 1'b1, 1'b0);

      // random part; odd phases use extreme settings, one phase runs with no idling
      // (the receiver's long hold-off falls into that one)
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_and_settle();
         no_idle = (p == 2);
         random_phase(RUNS_PER_PHASE, p[0]);
      end

      req_bus.valid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d drive results never arrived", $time, sb.pending());
         sb.errors += sb.pending();
      end

      $display("tb: %0d tick transactions, %0d register writes, %0d drive results checked",
               sb.ticks, sb.writes, sb.checked);
      $display("tb: %0d results clamped high, %0d clamped low", sb.n_high, sb.n_low);
      if (sb.errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off that backs up the block
   initial begin : result_sink
      int        stall;
      bit        held;
      drive_type got;
      stall = 0;
      held  = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{level: rsp_bus.drive_level, high: rsp_bus.clamped_high,
                    low: rsp_bus.clamped_low};
            sb.check_drive(got);
         end
         if (!held && sb.checked >= HOLD_AFTER) begin
            held  = 1'b1;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
   end

endmodule
